>>> rtl/core/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg
// Types and codes shared by the compacting deque store and its checker.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 4;
  localparam int OpW    = 2;
  localparam int StatW  = 2;

  localparam logic [OpW-1:0] OP_APPEND    = 2'd0;
  localparam logic [OpW-1:0] OP_POP_BACK  = 2'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT = 2'd2;

  localparam logic [StatW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic signed [WordW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] removed_value;
    logic [StatW-1:0]        status;
    logic [CountW-1:0]       entry_count;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/compacting_deque_store_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_deque_store_core
// Double-ended store of signed words held as one contiguous run in a RAM.
// ----------------------------------------------------------------------------
// A plain append or a refusal is settled on acceptance, and a removal reads
// the RAM in S_POP; the result strobe follows in the cycle after the last state.
// A compacting append moves the held entries down one slot in S_SHIFT
// through the single read and write port of the RAM, then appends in S_TAIL.
// One transaction is worked at a time; busy is high while a removal or a compacting append runs.
// Reset clears the control state; RAM contents stay undefined until written.
module compacting_deque_store_core #(
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire cds_pkg::in_item_t   in_data,
  output logic                     out_valid,
  output cds_pkg::out_item_t       out_data,
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [2:0]               paddr,
  input  wire  [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import cds_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = ((AW > CountW) ? AW : CountW) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_TAIL  = 2'd3;

  logic [WordW-1:0]  mem [DEPTH];
  logic [WordW-1:0]  rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [WordW-1:0]  mem_wd;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CountW-1:0] held_r, held_nxt;
  logic [CountW-1:0] idx_r, idx_nxt;
  logic [WordW-1:0]  word_r, word_nxt;
  logic [CountW-1:0] cap_r;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [SW-1:0]     cap_eff;
  logic [SW-1:0]     front_s, held_s, idx_s, tail_s;
  logic              accept, cfg_wr;

  assign accept = start && (state_r == S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_CAPACITY) ? {{(32-CountW){1'b0}}, cap_r} : 32'd0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign front_s = SW'(front_r);
  assign held_s  = SW'(held_r);
  assign idx_s   = SW'(idx_r);
  assign tail_s  = front_s + held_s;

  always_comb begin
    cap_eff = SW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = SW'(1);
    end else if (SW'(cap_r) > SW'(DEPTH)) begin
      cap_eff = SW'(DEPTH);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    held_nxt      = held_r;
    idx_nxt       = idx_r;
    word_nxt      = word_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = tail_s[AW-1:0];
    mem_wd        = in_data.value;
    mem_ra        = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.removed_value = '0;
          out_nxt.status        = ST_DONE;
          out_nxt.entry_count   = held_r;
          case (in_data.operation)
            OP_APPEND: begin
              if (held_s >= cap_eff) begin
                out_nxt.status = ST_FULL;
                out_valid_nxt  = 1'b1;
              end else if (held_r == '0) begin
                mem_we              = 1'b1;
                mem_wa              = '0;
                front_nxt           = '0;
                held_nxt            = CountW'(1);
                out_nxt.entry_count = CountW'(1);
                out_valid_nxt       = 1'b1;
              end else if (tail_s >= cap_eff) begin
                mem_ra    = front_r;
                idx_nxt   = '0;
                word_nxt  = in_data.value;
                state_nxt = S_SHIFT;
              end else begin
                mem_we              = 1'b1;
                held_nxt            = held_r + CountW'(1);
                out_nxt.entry_count = held_r + CountW'(1);
                out_valid_nxt       = 1'b1;
              end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
              if (held_r == '0) begin
                out_nxt.status = ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                held_nxt  = held_r - CountW'(1);
                state_nxt = S_POP;
                if (in_data.operation == OP_POP_BACK) begin
                  mem_ra = AW'(tail_s - SW'(1));
                end else begin
                  mem_ra    = front_r;
                  front_nxt = front_r + AW'(1);
                end
                if (held_r == CountW'(1)) begin
                  front_nxt = '0;
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        out_nxt.removed_value = rdata_r;
        out_nxt.status        = ST_DONE;
        out_nxt.entry_count   = held_r;
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = AW'(front_s + idx_s - SW'(1));
        mem_wd = rdata_r;
        if ((idx_r + CountW'(1)) < held_r) begin
          mem_ra  = AW'(front_s + idx_s + SW'(1));
          idx_nxt = idx_r + CountW'(1);
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        mem_we                = 1'b1;
        mem_wa                = AW'(tail_s - SW'(1));
        mem_wd                = word_r;
        front_nxt             = front_r - AW'(1);
        held_nxt              = held_r + CountW'(1);
        out_nxt.removed_value = '0;
        out_nxt.status        = ST_DONE;
        out_nxt.entry_count   = held_r + CountW'(1);
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      held_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= CountW'(8);
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      held_r      <= held_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (paddr[2] == CFG_CAPACITY)) begin
        cap_r <= pwdata[CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/cds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks on the compacting deque store, bound to its top level.
// ----------------------------------------------------------------------------
module cds_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     start,
  input wire                     busy,
  input wire                     out_valid,
  input wire cds_pkg::out_item_t out_data,
  input wire                     pready
);
  import cds_pkg::*;

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> out_data.entry_count != '0)
    else $error("full refusal with no entries held");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> out_data.entry_count == '0)
    else $error("empty refusal with entries held");

  a_refusal_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_DONE) |-> out_data.removed_value == '0)
    else $error("refused transaction returned a word");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy raised without an accepted transaction");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port stalled");

endmodule

bind compacting_deque_store_core cds_checker u_cds_checker (.*);
`default_nettype wire

>>> sim/compacting_deque_store_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_deque_store_core_tb
// Self-checking bench for the compacting deque store. A directed table walks
// the empty, full, compacting and ignored-operation cases, then bursts of
// random appends and removals run under a series of capacity settings.
// Results are checked against the table's expected values where it gives
// them, else against a predictor that tracks slots, front and count.
// ----------------------------------------------------------------------------
module compacting_deque_store_core_tb;
  import cds_pkg::*;

  localparam int DEPTH       = 8;
  localparam int PHASE_ITEMS = 165;
  localparam int WATCH_LIMIT = 1000;
  localparam int NUM_PHASES  = 9;
  localparam int DIR_ROWS    = 21;

  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0]     CAP_ADDR  = {CFG_CAPACITY, 2'b00};

  localparam logic signed [WordW-1:0] W_MAX  = 32'sh7fff_ffff;
  localparam logic signed [WordW-1:0] W_MIN  = 32'sh8000_0000;
  localparam logic signed [WordW-1:0] W_ONES = 32'shffff_ffff;

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic signed [WordW-1:0] value;
    logic                    typed;
    out_item_t               want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_item_t    in_data = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_data;
  logic [31:0] prdata;
  logic        pready;

  logic signed [WordW-1:0] slot_model [DEPTH];
  int          front_pos;
  int          held_cnt;
  logic [3:0]  cap_reg;

  out_item_t   pending_results [$];
  int          mismatches;
  int          items_sent;
  int          results_seen;
  int          n_compact;
  int          n_full;
  int          n_empty;
  int          idle_cycles;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{OP_POP_BACK,  32'sd0,          1'b1, '{32'sd0, ST_EMPTY, 4'd0}},
    '{OP_POP_FRONT, 32'sd0,          1'b1, '{32'sd0, ST_EMPTY, 4'd0}},
    '{OP_UNUSED,    W_ONES,          1'b1, '{32'sd0, ST_DONE,  4'd0}},
    '{OP_APPEND,    W_MAX,           1'b1, '{32'sd0, ST_DONE,  4'd1}},
    '{OP_APPEND,    W_MIN,           1'b1, '{32'sd0, ST_DONE,  4'd2}},
    '{OP_APPEND,    32'sd0,          1'b1, '{32'sd0, ST_DONE,  4'd3}},
    '{OP_APPEND,    W_ONES,          1'b1, '{32'sd0, ST_DONE,  4'd4}},
    '{OP_POP_FRONT, 32'sd0,          1'b1, '{W_MAX,  ST_DONE,  4'd3}},
    '{OP_POP_BACK,  32'sd0,          1'b1, '{W_ONES, ST_DONE,  4'd2}},
    '{OP_APPEND,    32'sha5a5_a5a5,  1'b0, '0},
    '{OP_APPEND,    32'sh5a5a_5a5a,  1'b0, '0},
    '{OP_APPEND,    32'sd1,          1'b0, '0},
    '{OP_APPEND,    32'sd2,          1'b0, '0},
    '{OP_APPEND,    32'sd3,          1'b0, '0},
    '{OP_APPEND,    32'sd4,          1'b0, '0},
    '{OP_APPEND,    32'sh1234_5678,  1'b1, '{32'sd0, ST_FULL,  4'd8}},
    '{OP_UNUSED,    32'sd0,          1'b1, '{32'sd0, ST_DONE,  4'd8}},
    '{OP_POP_FRONT, 32'sd0,          1'b0, '0},
    '{OP_POP_BACK,  32'sd0,          1'b0, '0},
    '{OP_APPEND,    32'sh0f0f_0f0f,  1'b0, '0},
    '{OP_APPEND,    32'shf0f0_f0f0,  1'b0, '0}
  };

  logic [3:0] cap_plan [NUM_PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd12,
                                        4'd5, 4'd8};

  compacting_deque_store_core #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic out_item_t deque_predict(input in_item_t item);
    out_item_t res;
    int        usable;
    int        i;
    res = '0;
    usable = (cap_reg == 4'd0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
    case (item.operation)
      OP_APPEND: begin
        if (held_cnt >= usable) begin
          res.status = ST_FULL;
          n_full++;
        end else if (held_cnt == 0) begin
          front_pos = 0;
          slot_model[0] = item.value;
          held_cnt = 1;
        end else if (front_pos + held_cnt >= usable) begin
          for (i = 0; i < held_cnt; i++) begin
            slot_model[front_pos - 1 + i] = slot_model[front_pos + i];
          end
          front_pos--;
          slot_model[front_pos + held_cnt] = item.value;
          held_cnt++;
          n_compact++;
        end else begin
          slot_model[front_pos + held_cnt] = item.value;
          held_cnt++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (held_cnt == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          if (item.operation == OP_POP_BACK) begin
            res.removed_value = slot_model[front_pos + held_cnt - 1];
          end else begin
            res.removed_value = slot_model[front_pos];
            front_pos++;
          end
          held_cnt--;
          if (held_cnt == 0) begin
            front_pos = 0;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = CountW'(held_cnt);
    return res;
  endfunction

  task automatic issue(input in_item_t item, input int gap, input logic typed,
                       input out_item_t want);
    out_item_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = deque_predict(item);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return 32'sd0;
      3:       return W_ONES;
      default: return $urandom;
    endcase
  endfunction

  // check each result transaction against the oldest expected result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: removed=%0d status=%0d count=%0d",
                   out_data.removed_value, out_data.status, out_data.entry_count);
        end
      end else begin
        automatic out_item_t want = pending_results.pop_front();
        if (out_data.removed_value !== want.removed_value ||
            out_data.status !== want.status ||
            out_data.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"mismatch: want removed=%0d status=%0d count=%0d, ",
                      "got removed=%0d status=%0d count=%0d"},
                     want.removed_value, want.status, want.entry_count,
                     out_data.removed_value, out_data.status, out_data.entry_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
        $display("compacting_deque_store_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    in_item_t item;
    int       p;
    int       k;
    int       r;
    int       burst_left;
    int       mode;
    int       gap;
    bit       idle_on;
    bit       quiet;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    n_compact    = 0;
    n_full       = 0;
    n_empty      = 0;
    idle_cycles  = 0;
    front_pos    = 0;
    held_cnt     = 0;
    cap_reg      = 4'd8;
    burst_left   = 0;
    mode         = 0;
    idle_on      = 1'b1;
    foreach (slot_model[i]) slot_model[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      item.operation = dir_table[r].operation;
      item.value     = dir_table[r].value;
      issue(item, (r % 5 == 4) ? $urandom_range(1, 10) : 0, dir_table[r].typed,
            dir_table[r].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      cfg_write(cap_plan[p]);
      quiet = (p == NUM_PHASES - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          mode       = $urandom_range(0, 2);
          idle_on    = ($urandom_range(0, 2) != 0);
        end
        burst_left--;
        case (mode)
          0: item.operation = ($urandom_range(0, 6) != 0) ? OP_APPEND
                              : OpW'($urandom_range(1, 2));
          1: item.operation = ($urandom_range(0, 6) != 0) ? OpW'($urandom_range(1, 2))
                              : OP_APPEND;
          default: item.operation = ($urandom_range(0, 7) == 0) ? OP_UNUSED
                                    : OpW'($urandom_range(0, 2));
        endcase
        item.value = pick_word();
        gap = 0;
        if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 10);
        end
        // hold off until the store has answered everything
        if (p == 4 && k == 80) begin
          settle();
        end
        issue(item, gap, 1'b0, '0);
      end
    end

    settle();
    $display("covered %0d operations, %0d results over %0d capacity settings",
             items_sent, results_seen, NUM_PHASES + 1);
    $display("compacting appends %0d, full refusals %0d, empty refusals %0d, mismatches %0d",
             n_compact, n_full, n_empty, mismatches);
    if (mismatches == 0) begin
      $display("compacting_deque_store_core regression: pass");
    end else begin
      $display("compacting_deque_store_core regression: fail");
    end
    $finish;
  end

endmodule
